// File: rtl/wfts_pkg.sv
package wfts_pkg;

    localparam int TIME_W  = 24;
    localparam int LEAST_W = 20;
    localparam int RATE_W  = 28;
    localparam int COUNT_W = 48;

    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [LEAST_W-1:0] t_least;
    typedef logic [RATE_W-1:0]  t_rate;
    typedef logic [COUNT_W-1:0] t_count;

    localparam t_least LEAST_START = 20'd1000000;
    localparam t_rate  RATE_NUM    = 28'd256000000;
    localparam t_count COUNT_MAX   = {COUNT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV_MEAN,
        ST_LOAD_RATE,
        ST_DIV_RATE,
        ST_DONE
    } t_state;

endpackage

// File: rtl/wfts_in_if.sv
interface wfts_in_if;
    logic                valid;
    logic                ready;
    wfts_pkg::t_time     frame_time_us;

    modport source (output valid, output frame_time_us, input ready);
    modport sink   (input valid, input frame_time_us, output ready);
endinterface

// File: rtl/wfts_out_if.sv
interface wfts_out_if;
    logic                valid;
    logic                ready;
    wfts_pkg::t_time     mean_time_us;
    wfts_pkg::t_least    least_time_us;
    wfts_pkg::t_time     most_time_us;
    wfts_pkg::t_rate     rate_q8;
    wfts_pkg::t_count    frames_seen;

    modport source (
        output valid, output mean_time_us, output least_time_us,
        output most_time_us, output rate_q8, output frames_seen,
        input ready
    );
    modport sink (
        input valid, input mean_time_us, input least_time_us,
        input most_time_us, input rate_q8, input frames_seen,
        output ready
    );
endinterface

// File: rtl/windowed_frame_time_stats.sv
// Sliding-window frame time statistics.
// i_in carries one frame duration in microseconds per word. The block stores
// it in a ring of WINDOW_DEPTH entries and returns one word on o_out with the
// truncated mean, the minimum (capped at one second), the maximum, the rate
// in Q8 frames per second and a 48-bit saturating frame count.
// Work per word: a write into the ring, a scan of the filled entries
// through the ring's registered read port, then two passes of one shared
// restoring divider (one quotient bit per cycle) for sum / filled and
// 256e6 / mean, with a setup step between the passes and a handoff step
// at the end. i_in.ready is high only while the block is idle, so a new
// word is taken only once the last result has been handed to the output
// register.
// The result sits in an output register; a stalled receiver does not stop
// the next word from being taken. A finished result waits in the last step
// until the output register is free.
// Reset empties the window and clears the count and output valid. The ring
// itself is not cleared: only entries written since reset are ever read.
module windowed_frame_time_stats #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wfts_in_if.sink       i_in,
    wfts_out_if.source    o_out
);
    import wfts_pkg::*;

    localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = TIME_W + CNT_W;
    localparam int DIV_W  = (SUM_W > RATE_W) ? SUM_W : RATE_W;
    localparam int STEP_W = $clog2(DIV_W + 1);
    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW_DEPTH - 1);

    t_time             r_ring [WINDOW_DEPTH];

    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_slot;
    t_count            r_total;
    t_count            n_total;
    logic [CNT_W-1:0]  r_filled;
    logic [CNT_W-1:0]  r_idx;
    logic              r_rd_vld;
    t_time             r_rd_data;
    logic [SUM_W-1:0]  r_sum;
    t_least            r_least;
    t_time             r_most;
    t_time             r_mean;

    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [DIV_W-1:0]  r_div;
    logic [STEP_W-1:0] r_step;

    logic              r_out_valid;
    t_time             r_out_mean;
    t_least            r_out_least;
    t_time             r_out_most;
    t_rate             r_out_rate;
    t_count            r_out_count;

    logic              w_accept;
    logic              w_issue;
    logic              w_scan_end;
    logic              w_div_last;
    logic              w_out_free;
    logic [DIV_W:0]    w_shift;
    logic              w_ge;
    logic [DIV_W:0]    w_diff;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_issue    = (r_idx < r_filled);
    assign w_scan_end = !w_issue && !r_rd_vld;
    assign w_div_last = (r_step == STEP_W'(DIV_W - 1));
    assign w_out_free = !r_out_valid || o_out.ready;
    assign n_total    = (r_total == COUNT_MAX) ? r_total : r_total + 1'b1;

    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign w_diff  = w_shift - {1'b0, r_div};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (w_accept) n_state = ST_SCAN;
            ST_SCAN:      if (w_scan_end) n_state = ST_DIV_MEAN;
            ST_DIV_MEAN:  if (w_div_last) n_state = ST_LOAD_RATE;
            ST_LOAD_RATE: n_state = ST_DIV_RATE;
            ST_DIV_RATE:  if (w_div_last) n_state = ST_DONE;
            ST_DONE:      if (w_out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = (r_state == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_slot  <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_slot  <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
                r_total <= n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ring[r_slot] <= i_in.frame_time_us;
        end
        if (r_state == ST_SCAN && w_issue) begin
            r_rd_data <= r_ring[r_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == ST_SCAN) && w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_filled <= (n_total >= COUNT_W'(WINDOW_DEPTH)) ? DEPTH_CNT
                                                            : n_total[CNT_W-1:0];
            r_idx    <= '0;
            r_sum    <= '0;
            r_least  <= LEAST_START;
            r_most   <= '0;
        end
        if (r_state == ST_SCAN) begin
            if (w_issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_rd_vld) begin
                r_sum <= r_sum + SUM_W'(r_rd_data);
                if (r_rd_data < {{(TIME_W-LEAST_W){1'b0}}, r_least}) begin
                    r_least <= r_rd_data[LEAST_W-1:0];
                end
                if (r_rd_data > r_most) begin
                    r_most <= r_rd_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && w_scan_end) begin
            r_rem  <= '0;
            r_quo  <= DIV_W'(r_sum);
            r_div  <= DIV_W'(r_filled);
            r_step <= '0;
        end else if (r_state == ST_LOAD_RATE) begin
            r_mean <= r_quo[TIME_W-1:0];
            r_rem  <= '0;
            r_quo  <= DIV_W'(RATE_NUM);
            r_div  <= r_quo;
            r_step <= '0;
        end else if (r_state == ST_DIV_MEAN || r_state == ST_DIV_RATE) begin
            r_rem  <= w_ge ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
            r_quo  <= {r_quo[DIV_W-2:0], w_ge};
            r_step <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_out_mean  <= r_mean;
            r_out_least <= r_least;
            r_out_most  <= r_most;
            r_out_rate  <= (r_mean == '0) ? '0 : r_quo[RATE_W-1:0];
            r_out_count <= r_total;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.mean_time_us  = r_out_mean;
    assign o_out.least_time_us = r_out_least;
    assign o_out.most_time_us  = r_out_most;
    assign o_out.rate_q8       = r_out_rate;
    assign o_out.frames_seen   = r_out_count;

    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state) == ST_DONE)
        else $error("output valid rose outside the final step");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= r_filled) && (r_filled != '0))
        else $error("scan index beyond filled entries");

    a_least_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.least_time_us <= LEAST_START)
        else $error("minimum above one second cap");

    a_mean_le_most: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.mean_time_us <= o_out.most_time_us)
        else $error("mean above maximum");

endmodule
